// ----- rtl/npcm_pkg.sv -----
`timescale 1ns / 1ps

package npcm_pkg;

    // field widths
    localparam int ARGB_W  = 32;
    localparam int CHAN_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int DIST_W  = 18;

    // default palette depth
    localparam int PALETTE_SIZE_DEF = 16;

    // beat packing
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // request kinds carried in s_tuser
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_MAP   = 1'b1
    } req_kind_t;

    // compare result of one palette entry against the pixel
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] sq_sum;
    } cmp_res_t;

    // squared difference of two 8-bit channels
    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

// ----- rtl/npcm_palette_ram.sv -----
`timescale 1ns / 1ps

module npcm_palette_ram #(
    parameter int DEPTH  = npcm_pkg::PALETTE_SIZE_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [npcm_pkg::ARGB_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [npcm_pkg::ARGB_W-1:0] rdata
);

    logic [npcm_pkg::ARGB_W-1:0] mem [DEPTH];
    logic [npcm_pkg::ARGB_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/npcm_dist_unit.sv -----
`timescale 1ns / 1ps

module npcm_dist_unit (
    input  logic [npcm_pkg::ARGB_W-1:0] entry,
    input  logic [npcm_pkg::ARGB_W-1:0] pixel,
    output npcm_pkg::cmp_res_t          res
);

    localparam int SQ_W = 2 * npcm_pkg::CHAN_W;

    logic [SQ_W-1:0] sq_a, sq_r, sq_g, sq_b;

    // per-channel squared differences
    assign sq_a = npcm_pkg::sq_diff(entry[31:24], pixel[31:24]);
    assign sq_r = npcm_pkg::sq_diff(entry[23:16], pixel[23:16]);
    assign sq_g = npcm_pkg::sq_diff(entry[15:8],  pixel[15:8]);
    assign sq_b = npcm_pkg::sq_diff(entry[7:0],   pixel[7:0]);

    // sum of squares, plus exact match or both fully transparent
    always_comb begin
        res.sq_sum = npcm_pkg::DIST_W'(sq_a) + npcm_pkg::DIST_W'(sq_r)
                   + npcm_pkg::DIST_W'(sq_g) + npcm_pkg::DIST_W'(sq_b);
        res.hit    = (entry == pixel) || ((entry[31:24] == '0) && (pixel[31:24] == '0));
    end

endmodule

// ----- rtl/nearest_palette_color_map_unit.sv -----
`timescale 1ns / 1ps

// Nearest palette color mapper.
// Input beats on s_* carry either a palette write (s_tuser = write) or a
// pixel to map (s_tuser = map). A write stores one ARGB entry and gives no
// output beat. A map beat gives one output beat on m_*: the index and color
// of the first exact or fully transparent match, else of the nearest entry
// by squared RGBA distance, lower index on ties.
// The cfg channel sets the number of entries in use; zero passes pixels
// through with m_tuser high. Write it only while the block is idle.
// A write beat leaves the block idle. A map beat is scanned over the n
// entries in use before the next beat is taken: the single palette memory
// read port delivers one entry per cycle to one distance unit through a
// registered read, then the result is handed to the output register and
// the block returns to idle. A match ends the scan early. A pass-through
// beat goes straight to the hand-off step.
// Reset clears the control state and the entry count; palette contents are
// undefined until written. When m_tready is low the finished result waits
// in the output register and the next input beat can still be taken;
// a second result then waits until the output register frees.
module nearest_palette_color_map_unit #(
    parameter int PALETTE_SIZE = npcm_pkg::PALETTE_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // entry_index [3:0], entry_color [35:4], pixel_color [67:36]
    input  logic [npcm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [0]
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // palette_index [3:0], mapped_color [35:4]
    output logic [npcm_pkg::M_TDATA_W-1:0] m_tdata,
    // passed_through [0]
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [npcm_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam int ARGB_W = npcm_pkg::ARGB_W;
    localparam int DIST_W = npcm_pkg::DIST_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [npcm_pkg::COUNT_W-1:0] count_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ARGB_W-1:0] pix_reg, pix_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [ARGB_W-1:0] best_color_reg, best_color_next;
    logic              pt_reg, pt_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [npcm_pkg::SLOT_W-1:0] m_idx_reg, m_idx_next;
    logic [ARGB_W-1:0]        m_color_reg, m_color_next;
    logic                     m_pt_reg, m_pt_next;

    logic [npcm_pkg::SLOT_W-1:0] in_slot;
    logic [ARGB_W-1:0]        in_ecol;
    logic [ARGB_W-1:0]        in_pix;
    logic                     in_beat;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [ARGB_W-1:0]        rd_data;
    logic                     issuing;
    logic                     last_entry;
    logic [CNT_W-1:0]         count_clamped;
    npcm_pkg::cmp_res_t       cmp;

    // unpack the input beat
    assign in_slot = s_tdata[3:0];
    assign in_ecol = s_tdata[35:4];
    assign in_pix  = s_tdata[67:36];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // palette writes, slots beyond the table are dropped
    assign wr_en   = in_beat && (s_tuser == npcm_pkg::REQ_WRITE)
                   && (32'(in_slot) < 32'(PALETTE_SIZE));
    assign wr_addr = IDX_W'(in_slot);

    // entries in use, held to the table depth
    assign count_clamped = (32'(count_reg) > 32'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                                : CNT_W'(count_reg);

    npcm_palette_ram #(
        .DEPTH  (PALETTE_SIZE),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_ecol),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    npcm_dist_unit u_dist (
        .entry (rd_data),
        .pixel (pix_reg),
        .res   (cmp)
    );

    assign issuing    = (state_reg == S_SCAN) && (issue_cnt_reg < n_reg);
    assign last_entry = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == n_reg;

    // scan control and result hand-off
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = issuing;
        rd_idx_next     = issue_cnt_reg[IDX_W-1:0];
        pix_next        = pix_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_color_next = best_color_reg;
        pt_next         = pt_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_idx_next      = m_idx_reg;
        m_color_next    = m_color_reg;
        m_pt_next       = m_pt_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (issuing) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat && (s_tuser == npcm_pkg::REQ_MAP)) begin
                    pix_next       = in_pix;
                    n_next         = count_clamped;
                    issue_cnt_next = '0;
                    best_idx_next  = '0;
                    best_dist_next = '1;
                    if (count_clamped == '0) begin
                        best_color_next = in_pix;
                        pt_next         = 1'b1;
                        state_next      = S_FIN;
                    end else begin
                        pt_next    = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_valid_reg) begin
                    if (cmp.hit) begin
                        best_idx_next   = rd_idx_reg;
                        best_color_next = rd_data;
                        state_next      = S_FIN;
                    end else begin
                        if (cmp.sq_sum < best_dist_reg) begin
                            best_idx_next   = rd_idx_reg;
                            best_dist_next  = cmp.sq_sum;
                            best_color_next = rd_data;
                        end
                        if (last_entry) begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_idx_next    = npcm_pkg::SLOT_W'(best_idx_reg);
                    m_color_next  = best_color_reg;
                    m_pt_next     = pt_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, scan registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
        n_reg          <= n_next;
        issue_cnt_reg  <= issue_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        pix_reg        <= pix_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        best_color_reg <= best_color_next;
        pt_reg         <= pt_next;
        m_idx_reg      <= m_idx_next;
        m_color_reg    <= m_color_next;
        m_pt_reg       <= m_pt_next;
    end

    // pack the output beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_color_reg, m_idx_reg};
    assign m_tuser  = m_pt_reg;

endmodule
